FILE: hdl/msp_pkg.sv
`default_nettype none
package msp_pkg;

  localparam int FIELD_BYTES_DEF = 24;
  localparam int CountW = 12;

  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_EOL    = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [1:0] KIND_ADDR = 2'd0;
  localparam logic [1:0] KIND_NAME = 2'd1;
  localparam logic [1:0] KIND_STAT = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_DELIM   = 3'd1,
    PH_DELIM_WS = 3'd2,
    PH_ENTRY   = 3'd3,
    PH_IGNORE  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_STRIP = 3'd1,
    S_ADDR  = 3'd2,
    S_NAME  = 3'd3,
    S_STAT  = 3'd4
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic idle;
    logic in_strip;
    logic strip_step;
    logic emit_addr;
    logic emit_name;
    logic emit_stat;
    logic entry_done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_emit;
    logic strip_more;
    logic addr_last;
    logic name_empty;
    logic name_last;
    logic stat_pend;
    logic out_free;
  } stat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/msp_ctrl.sv
`default_nettype none
module msp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire msp_pkg::stat_t st,
  output msp_pkg::cmd_t      cmd
);
  import msp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (st.start_emit) state_next = S_STRIP;
      S_STRIP: if (!st.strip_more) state_next = S_ADDR;
      S_ADDR: begin
        if (st.out_free && st.addr_last) begin
          if (!st.name_empty) state_next = S_NAME;
          else if (st.stat_pend) state_next = S_STAT;
          else state_next = S_IDLE;
        end
      end
      S_NAME: begin
        if (st.out_free && st.name_last) state_next = st.stat_pend ? S_STAT : S_IDLE;
      end
      S_STAT:  if (st.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:  cmd.idle = 1'b1;
      S_STRIP: begin
        cmd.in_strip   = 1'b1;
        cmd.strip_step = st.strip_more;
      end
      S_ADDR: begin
        cmd.emit_addr  = st.out_free;
        cmd.entry_done = st.out_free && st.addr_last && st.name_empty && !st.stat_pend;
      end
      S_NAME: begin
        cmd.emit_name  = st.out_free;
        cmd.entry_done = st.out_free && st.name_last && !st.stat_pend;
      end
      S_STAT: begin
        cmd.emit_stat  = st.out_free;
        cmd.entry_done = st.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/msp_dp.sv
`default_nettype none
module msp_dp #(
  parameter int FIELD_BYTES = msp_pkg::FIELD_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire msp_pkg::cmd_t               cmd,
  output msp_pkg::stat_t                   st,
  input  wire logic                        s_valid,
  output logic                             s_ready,
  input  wire logic [7:0]                  s_byte,
  input  wire logic [1:0]                  s_op,
  input  wire logic                        m_ready,
  output logic                             m_valid,
  output logic [1:0]                       m_kind,
  output logic [7:0]                       m_char,
  output logic [1:0]                       m_status,
  output logic [msp_pkg::CountW-1:0]       m_count,
  output logic                             m_last,
  input  wire logic                        cfg_wr,
  input  wire logic [msp_pkg::CountW-1:0]  cfg_val
);
  import msp_pkg::*;

  localparam int LW = $clog2(FIELD_BYTES + 1);
  localparam int IW = $clog2(FIELD_BYTES);
  localparam logic [LW-1:0] FULL = LW'(FIELD_BYTES);

  logic [7:0] nstore [FIELD_BYTES];
  logic [7:0] astore [FIELD_BYTES];

  logic [7:0]        depth, depth_next;
  logic              quote, quote_next, esc, esc_next, br, br_next, wa, wa_next;
  logic              eo, eo_next, swap, swap_next, spend, spend_next;
  logic [LW-1:0]     nl, nl_next, al, al_next, idx;
  phase_t            phase, phase_next;
  logic [1:0]        lres, lres_next;
  logic [CountW-1:0] done, done_next, maxe;
  logic              wr_n, wr_a, go, ld_stat;
  logic [1:0]        ld_code;

  logic              fire, refuse;
  logic [7:0]        c, d1, d2, rd_name, rd_addr;
  logic              q1, special, fin_ok;
  logic [LW-1:0]     nlm1, alen, nlen;

  assign c      = s_byte;
  assign s_ready = cmd.idle && st.out_free;
  assign fire   = s_valid && s_ready;
  assign refuse = done >= maxe;
  assign nlm1   = nl - LW'(1);
  assign alen   = swap ? nl : al;
  assign nlen   = swap ? '0 : nl;
  assign rd_name = nstore[cmd.in_strip ? nlm1[IW-1:0] : idx[IW-1:0]];
  assign rd_addr = astore[idx[IW-1:0]];

  assign st.out_free   = !m_valid || m_ready;
  assign st.start_emit = go;
  assign st.strip_more = !swap && (nl != '0) && is_ws(rd_name);
  assign st.addr_last  = (idx == alen - LW'(1));
  assign st.name_empty = (nlen == '0);
  assign st.name_last  = (idx == nlen - LW'(1));
  assign st.stat_pend  = spend;

  // one byte of the parser
  assign d1 = (c == CH_LPAREN && !esc && !quote && depth != 8'd255) ? depth + 8'd1 : depth;
  assign q1 = (c == CH_DQUOTE && !esc && d1 == 8'd0) ? !quote : quote;
  assign special = (d1 == 8'd0) && !q1 && !esc;
  assign d2 = (c == CH_RPAREN && !esc && !q1 && d1 != 8'd0) ? d1 - 8'd1 : d1;
  assign fin_ok = !esc && depth == 8'd0 && !quote && !br && !(nl == '0 && al == '0);

  always_comb begin
    depth_next = depth; quote_next = quote; esc_next = esc; br_next = br; wa_next = wa;
    eo_next = eo; swap_next = swap; spend_next = spend; nl_next = nl; al_next = al;
    phase_next = phase; lres_next = lres; done_next = done;
    wr_n = 1'b0; wr_a = 1'b0; go = 1'b0; ld_stat = 1'b0; ld_code = ST_OK;
    if (fire) begin
      case (s_op)
        OP_BYTE: begin
          if (c != 8'd0) begin
            if (phase == PH_START && refuse) begin
              phase_next = PH_IGNORE;
              lres_next  = ST_REFUSED;
            end else if (phase != PH_IGNORE) begin
              if (phase != PH_ENTRY && is_ws(c)) begin
                if (phase == PH_DELIM) phase_next = PH_DELIM_WS;
              end else begin
                phase_next = PH_ENTRY;
                eo_next    = 1'b1;
                if (special && ((c == CH_LT && br) || (c == CH_GT && !br) ||
                    ((c == CH_COMMA || c == CH_SEMI) && !fin_ok))) begin
                  depth_next = '0; quote_next = 1'b0; esc_next = 1'b0; br_next = 1'b0;
                  wa_next = 1'b0; eo_next = 1'b0; nl_next = '0; al_next = '0;
                  phase_next = PH_IGNORE;
                  lres_next  = ST_BAD;
                end else if (special && c == CH_LT) begin
                  wa_next = 1'b1;
                  br_next = 1'b1;
                end else if (special && c == CH_GT) begin
                  br_next = 1'b0;
                end else if (special && (c == CH_COMMA || c == CH_SEMI)) begin
                  depth_next = '0; quote_next = 1'b0; esc_next = 1'b0; br_next = 1'b0;
                  wa_next = 1'b0; eo_next = 1'b0;
                  swap_next  = (al == '0);
                  spend_next = 1'b0;
                  if (done != '1) done_next = done + CountW'(1);
                  phase_next = PH_DELIM;
                  go = 1'b1;
                end else begin
                  depth_next = d2;
                  quote_next = q1;
                  esc_next   = (c == CH_BSLASH) && !esc && d2 == 8'd0 && !q1;
                  if (wa) begin
                    if (al < FULL) begin
                      wr_a = 1'b1;
                      al_next = al + LW'(1);
                    end
                  end else if (nl < FULL) begin
                    wr_n = 1'b1;
                    nl_next = nl + LW'(1);
                  end
                end
              end
            end
          end
        end
        OP_EOL: begin
          ld_stat = 1'b1;
          if (phase == PH_START) ld_code = refuse ? ST_REFUSED : ST_BAD;
          else if (phase == PH_DELIM_WS) ld_code = ST_BAD;
          else ld_code = lres;
          phase_next = PH_START;
          lres_next  = ST_OK;
        end
        OP_FINISH: begin
          phase_next = PH_START;
          lres_next  = ST_OK;
          if (!eo) begin
            ld_stat = 1'b1;
            ld_code = ST_NONE;
          end else begin
            depth_next = '0; quote_next = 1'b0; esc_next = 1'b0; br_next = 1'b0;
            wa_next = 1'b0; eo_next = 1'b0;
            if (fin_ok) begin
              swap_next  = (al == '0);
              spend_next = 1'b1;
              if (done != '1) done_next = done + CountW'(1);
              go = 1'b1;
            end else begin
              nl_next = '0; al_next = '0;
              ld_stat = 1'b1;
              ld_code = ST_BAD;
            end
          end
        end
        default: ;
      endcase
    end
    if (cmd.strip_step) nl_next = nlm1;
    if (cmd.entry_done) begin
      nl_next = '0;
      al_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_n) nstore[nl[IW-1:0]] <= c;
    if (wr_a) astore[al[IW-1:0]] <= c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0; quote <= 1'b0; esc <= 1'b0; br <= 1'b0; wa <= 1'b0; eo <= 1'b0;
      swap <= 1'b0; spend <= 1'b0; nl <= '0; al <= '0; idx <= '0;
      phase <= PH_START; lres <= ST_OK; done <= '0; maxe <= CountW'(1000);
      m_valid <= 1'b0;
    end else begin
      depth <= depth_next; quote <= quote_next; esc <= esc_next; br <= br_next;
      wa <= wa_next; eo <= eo_next; swap <= swap_next; spend <= spend_next;
      nl <= nl_next; al <= al_next; phase <= phase_next; lres <= lres_next;
      done <= done_next;
      if (cfg_wr) maxe <= cfg_val;
      if (go) idx <= '0;
      else if (cmd.emit_addr) idx <= st.addr_last ? '0 : idx + LW'(1);
      else if (cmd.emit_name) idx <= idx + LW'(1);
      if (ld_stat || cmd.emit_addr || cmd.emit_name || cmd.emit_stat) m_valid <= 1'b1;
      else if (m_ready) m_valid <= 1'b0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (ld_stat || cmd.emit_stat) begin
      m_kind   <= KIND_STAT;
      m_char   <= 8'd0;
      m_status <= cmd.emit_stat ? ST_OK : ld_code;
      m_count  <= done;
      m_last   <= 1'b1;
    end else if (cmd.emit_addr) begin
      m_kind   <= KIND_ADDR;
      m_char   <= swap ? rd_name : rd_addr;
      m_status <= ST_OK;
      m_count  <= done;
      m_last   <= st.addr_last && st.name_empty && !spend;
    end else if (cmd.emit_name) begin
      m_kind   <= KIND_NAME;
      m_char   <= rd_name;
      m_status <= ST_OK;
      m_count  <= done;
      m_last   <= st.name_last && !spend;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mail_address_list_splitter_unit.sv
`default_nettype none
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: byte_value; tuser: op
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: char_out,status,entry_number;
//                                              tuser: kind; tlast: last
// cfg       in   cfg_valid/cfg_ready           cfg_data: max_entries
//
// Ordinary header bytes are taken straight in. A completed entry holds the input
// while the name tail is checked, while trailing name blanks are stripped one by
// one, and while each word is emitted (address bytes, name bytes, and the closing
// status on finish), paced by the single output register. Input is taken only while
// the output register is free.
// Synchronous reset clears all parse state and sets max_entries to 1000.
module mail_address_list_splitter_unit #(
  parameter int FIELD_BYTES = msp_pkg::FIELD_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] char_out, [9:8] status,
                                           // [21:10] entry_number, [23:22] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [11:0] cfg_data        // max_entries
);
  import msp_pkg::*;

  cmd_t              cmd;
  stat_t             st;
  logic [7:0]        m_char;
  logic [1:0]        m_status;
  logic [CountW-1:0] m_count;

  // register always writable
  assign cfg_ready = 1'b1;

  msp_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  msp_dp #(.FIELD_BYTES(FIELD_BYTES)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_byte   (s_axis_tdata),
    .s_op     (s_axis_tuser),
    .m_ready  (m_axis_tready),
    .m_valid  (m_axis_tvalid),
    .m_kind   (m_axis_tuser),
    .m_char   (m_char),
    .m_status (m_status),
    .m_count  (m_count),
    .m_last   (m_axis_tlast),
    .cfg_wr   (cfg_valid),
    .cfg_val  (cfg_data)
  );

  // pack the result word, pad to whole bytes
  assign m_axis_tdata = {2'b00, m_count, m_status, m_char};

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import msp_pkg::*;

  localparam int FIELD_BYTES = FIELD_BYTES_DEF;
  localparam int STALL_LIMIT = 3000;   // cycles with no handshake anywhere
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int DRAIN_CYCLES = 60;    // settle time once nothing is expected

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] byte_value
  logic [1:0]  s_axis_tuser;   // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] char_out, [9:8] status, [21:10] entry_number
  logic [1:0]  m_axis_tuser;   // [1:0] kind
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [11:0] cfg_data;       // max_entries

  mail_address_list_splitter_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One output word as the splitter should present it
  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [1:0]  st;
    logic [11:0] num;
    logic        last;
  } out_word_t;

  out_word_t pending_words[$];
  int        mismatches = 0;
  bit        rx_hold_req = 1'b0;
  bit        quiet = 1'b1;         // no idling on either side while set

  // Shadow of the splitter's parse state
  logic [11:0] sh_max_entries;
  logic [7:0]  sh_depth;
  bit          sh_quote, sh_escape, sh_bracket, sh_to_addr, sh_open;
  logic [7:0]  sh_name [FIELD_BYTES];
  logic [7:0]  sh_addr [FIELD_BYTES];
  int          sh_name_len, sh_addr_len;
  phase_t      sh_phase;
  logic [1:0]  sh_line_res;
  logic [11:0] sh_done;

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void queue_word(input logic [1:0] kind, input logic [7:0] ch,
                                     input logic [1:0] st);
    out_word_t w;
    w.kind = kind; w.ch = ch; w.st = st; w.num = sh_done; w.last = 1'b0;
    pending_words.push_back(w);
  endfunction

  function automatic void drop_entry();
    sh_depth = 8'd0;
    sh_quote = 1'b0; sh_escape = 1'b0; sh_bracket = 1'b0;
    sh_to_addr = 1'b0; sh_open = 1'b0;
    sh_name_len = 0; sh_addr_len = 0;
  endfunction

  function automatic void mark_bad();
    drop_entry();
    sh_phase = PH_IGNORE;
    sh_line_res = ST_BAD;
  endfunction

  // Emit a completed entry; return 0 where it is malformed
  function automatic bit close_entry();
    if (sh_escape || sh_depth != 8'd0 || sh_quote || sh_bracket) return 1'b0;
    if (sh_name_len == 0 && sh_addr_len == 0) return 1'b0;
    if (sh_addr_len == 0) begin
      sh_addr = sh_name;
      sh_addr_len = sh_name_len;
      sh_name_len = 0;
    end
    while (sh_name_len > 0 && is_blank(sh_name[sh_name_len-1])) sh_name_len--;
    if (sh_done != 12'hFFF) sh_done++;
    for (int i = 0; i < sh_addr_len; i++) queue_word(KIND_ADDR, sh_addr[i], ST_OK);
    for (int i = 0; i < sh_name_len; i++) queue_word(KIND_NAME, sh_name[i], ST_OK);
    drop_entry();
    return 1'b1;
  endfunction

  function automatic void entry_char(input logic [7:0] c);
    if (c == CH_LPAREN && !sh_escape && !sh_quote && sh_depth != 8'hFF) sh_depth++;
    if (c == CH_DQUOTE && !sh_escape && sh_depth == 8'd0) sh_quote = !sh_quote;
    if (sh_depth == 8'd0 && !sh_quote && !sh_escape) begin
      if ((c == CH_LT && sh_bracket) || (c == CH_GT && !sh_bracket)) begin
        mark_bad();
        return;
      end
      if (c == CH_LT) begin
        sh_to_addr = 1'b1;
        sh_bracket = 1'b1;
        return;
      end
      if (c == CH_GT) begin
        sh_bracket = 1'b0;
        return;
      end
      if (c == CH_COMMA || c == CH_SEMI) begin
        if (close_entry()) sh_phase = PH_DELIM;
        else mark_bad();
        return;
      end
    end
    if (c == CH_RPAREN && !sh_escape && !sh_quote && sh_depth != 8'd0) sh_depth--;
    sh_escape = (c == CH_BSLASH && !sh_escape && sh_depth == 8'd0 && !sh_quote);
    if (sh_to_addr) begin
      if (sh_addr_len < FIELD_BYTES) sh_addr[sh_addr_len++] = c;
    end else begin
      if (sh_name_len < FIELD_BYTES) sh_name[sh_name_len++] = c;
    end
  endfunction

  // Work out the words caused by one accepted input word
  function automatic void parse_step(input logic [1:0] op, input logic [7:0] c);
    int before_n;
    logic [1:0] st;
    before_n = pending_words.size();
    case (op)
      OP_BYTE: begin
        if (c != 8'd0) begin
          if (sh_phase == PH_START && sh_done >= sh_max_entries) begin
            sh_phase = PH_IGNORE;
            sh_line_res = ST_REFUSED;
          end
          if (sh_phase != PH_IGNORE) begin
            if (sh_phase != PH_ENTRY && is_blank(c)) begin
              if (sh_phase == PH_DELIM) sh_phase = PH_DELIM_WS;
            end else begin
              if (sh_phase != PH_ENTRY) begin
                sh_phase = PH_ENTRY;
                sh_open = 1'b1;
              end
              entry_char(c);
            end
          end
        end
      end
      OP_EOL: begin
        st = sh_line_res;
        if (sh_phase == PH_START) st = (sh_done >= sh_max_entries) ? ST_REFUSED : ST_BAD;
        else if (sh_phase == PH_DELIM_WS) st = ST_BAD;
        queue_word(KIND_STAT, 8'd0, st);
        sh_phase = PH_START;
        sh_line_res = ST_OK;
      end
      OP_FINISH: begin
        if (!sh_open) queue_word(KIND_STAT, 8'd0, ST_NONE);
        else if (close_entry()) queue_word(KIND_STAT, 8'd0, ST_OK);
        else begin
          drop_entry();
          queue_word(KIND_STAT, 8'd0, ST_BAD);
        end
        sh_phase = PH_START;
        sh_line_res = ST_OK;
      end
      default: ;
    endcase
    if (pending_words.size() > before_n) pending_words[$].last = 1'b1;
  endfunction

  // Sender side: offer one word, hold it until taken, then predict
  task automatic send_word(input logic [1:0] op, input logic [7:0] c);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= c;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    parse_step(op, c);
  endtask

  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 19);
    if (quiet || r > 3) return;
    n = (r == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic feed(input logic [1:0] op, input logic [7:0] c);
    sender_gap();
    send_word(op, c);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_entries(input logic [11:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sh_max_entries = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 82) return 8'd32;
    if (r < 86) return 8'($urandom_range(9, 13));
    if (r < 89) return CH_DQUOTE;
    if (r < 92) return CH_BSLASH;
    if (r < 94) return CH_LPAREN;
    if (r < 96) return CH_RPAREN;
    return 8'($urandom_range(128, 255));
  endfunction

  // One entry: optional display name, optional comment, optional bracketed address
  task automatic feed_entry(input bit with_delim, inout int items);
    int nlen;
    int alen;
    nlen = ($urandom_range(0, 11) == 0) ? 28 : $urandom_range(0, 6);
    for (int i = 0; i < nlen; i++) begin
      feed(OP_BYTE, text_char());
      items++;
    end
    if ($urandom_range(0, 7) == 0) begin
      feed(OP_BYTE, CH_LPAREN); feed(OP_BYTE, 8'h63); feed(OP_BYTE, CH_RPAREN);
      items += 3;
    end
    if ($urandom_range(0, 2) != 0) begin
      feed(OP_BYTE, CH_LT);
      alen = ($urandom_range(0, 11) == 0) ? 30 : $urandom_range(1, 8);
      for (int i = 0; i < alen; i++)
        feed(OP_BYTE, (i == alen / 2) ? 8'h40 : 8'h61 + 8'($urandom_range(0, 25)));
      feed(OP_BYTE, CH_GT);
      items += alen + 2;
      if ($urandom_range(0, 3) == 0) begin
        feed(OP_BYTE, 8'd32);
        items++;
      end
    end
    if (with_delim) begin
      feed(OP_BYTE, $urandom_range(0, 1) ? CH_COMMA : CH_SEMI);
      items++;
    end
  endtask

  task automatic feed_line(inout int items);
    int n;
    n = $urandom_range(1, 3);
    if ($urandom_range(0, 3) == 0) begin
      feed(OP_BYTE, 8'd32);
      items++;
    end
    for (int e = 0; e < n; e++) feed_entry(e < n - 1 || $urandom_range(0, 1), items);
    feed($urandom_range(0, 7) == 0 ? OP_FINISH : OP_EOL, 8'd0);
    items++;
  endtask

  // Directed rows: chk marks a status that can be read off directly
  typedef struct {
    logic [1:0] op;
    logic [7:0] ch;
    bit         chk;
    logic [1:0] st;
  } drow_t;

  localparam int NDIR = 25;
  drow_t dir_rows [NDIR] = '{
    '{OP_EOL,    8'h00,     1'b1, ST_BAD},   // blank line straight after reset
    '{OP_FINISH, 8'h00,     1'b1, ST_NONE},  // finish with nothing open
    '{OP_BYTE,   8'h00,     1'b0, ST_OK},    // zero byte, ignored
    '{2'd3,      8'hFF,     1'b0, ST_OK},    // unused op, ignored
    '{OP_BYTE,   8'h20,     1'b0, ST_OK},    // leading blank skipped
    '{OP_BYTE,   8'h61,     1'b0, ST_OK},
    '{OP_BYTE,   CH_LT,     1'b0, ST_OK},
    '{OP_BYTE,   8'h62,     1'b0, ST_OK},
    '{OP_BYTE,   CH_GT,     1'b0, ST_OK},
    '{OP_BYTE,   CH_COMMA,  1'b0, ST_OK},    // emits address then name
    '{OP_EOL,    8'h00,     1'b1, ST_OK},    // delimiter at end of line
    '{OP_BYTE,   CH_GT,     1'b0, ST_OK},    // stray closing bracket
    '{OP_BYTE,   8'h78,     1'b0, ST_OK},    // rest of line ignored
    '{OP_EOL,    8'h00,     1'b1, ST_BAD},
    '{OP_BYTE,   CH_LPAREN, 1'b0, ST_OK},
    '{OP_BYTE,   CH_RPAREN, 1'b0, ST_OK},
    '{OP_BYTE,   CH_DQUOTE, 1'b0, ST_OK},
    '{OP_BYTE,   CH_BSLASH, 1'b0, ST_OK},    // escape inside quotes is plain
    '{OP_BYTE,   CH_DQUOTE, 1'b0, ST_OK},
    '{OP_BYTE,   8'h61,     1'b0, ST_OK},
    '{OP_BYTE,   8'hFF,     1'b0, ST_OK},
    '{OP_BYTE,   CH_SEMI,   1'b0, ST_OK},    // name becomes the address
    '{OP_BYTE,   8'h09,     1'b0, ST_OK},
    '{OP_EOL,    8'h00,     1'b1, ST_BAD},   // delimiter then blanks only
    '{OP_FINISH, 8'h00,     1'b1, ST_NONE}
  };

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    int gap;
    int r;
    gap = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (gap > 0) begin
        m_axis_tready <= 1'b0;
        gap--;
      end else begin
        m_axis_tready <= 1'b1;
        r = $urandom_range(0, 19);
        if (!quiet && r < 4) gap = (r == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
    end
  end

  // Compare every word taken from the output with the oldest prediction
  always @(posedge clk) begin
    out_word_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: kind %0d char %02h status %0d entry %0d last %0b",
                   m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[9:8],
                   m_axis_tdata[21:10], m_axis_tlast);
      end else begin
        w = pending_words.pop_front();
        if (m_axis_tuser !== w.kind || m_axis_tdata[7:0] !== w.ch ||
            m_axis_tdata[9:8] !== w.st || m_axis_tdata[21:10] !== w.num ||
            m_axis_tdata[23:22] !== 2'b00 || m_axis_tlast !== w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want kind %0d char %02h status %0d entry %0d last %0b, %s",
                     w.kind, w.ch, w.st, w.num, w.last,
                     $sformatf("got kind %0d char %02h status %0d entry %0d last %0b top %0b",
                               m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[9:8],
                               m_axis_tdata[21:10], m_axis_tlast, m_axis_tdata[23:22]));
        end
      end
    end
  end

  // Watchdog: too long with no handshake on any channel
  always @(posedge clk) begin
    int idle_cycles;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [11:0] settings [6];
    int items;
    bit paused;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tuser  = OP_BYTE;
    cfg_valid     = 1'b0;
    cfg_data      = 12'd0;
    paused        = 1'b0;
    sh_max_entries = 12'd1000;
    drop_entry();
    sh_phase = PH_START;
    sh_line_res = ST_OK;
    sh_done = 12'd0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table at full rate
    for (int i = 0; i < NDIR; i++) begin
      send_word(dir_rows[i].op, dir_rows[i].ch);
      if (dir_rows[i].chk && (pending_words.size() == 0 ||
                              pending_words[$].st !== dir_rows[i].st)) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d: status not %0d", i, dir_rows[i].st);
      end
    end
    wait_drained();

    // Limits: wide open, tight, one, zero, random, back to reset value
    settings = '{12'd4095, 12'd3, 12'd1, 12'd0, 12'($urandom_range(1, 4095)), 12'd1000};
    for (int p = 0; p < 6; p++) begin
      write_max_entries(settings[p]);
      quiet = (p == 2);
      items = 0;
      while (items < 34) begin
        // long receiver hold-off while the sender keeps offering
        if (p == 0 && items == 0) rx_hold_req = 1'b1;
        if ($urandom_range(0, 6) == 0) begin
          feed(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          items++;
        end else begin
          feed_line(items);
        end
        if (p == 1 && !paused) begin
          // hold the sender until every predicted word has been seen
          @(negedge clk);
          s_axis_tvalid <= 1'b0;
          while (pending_words.size() != 0) @(negedge clk);
          paused = 1'b1;
        end
      end
      feed(OP_FINISH, 8'd0);
      wait_drained();
    end

    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
